// ===== rtl/hpg_pkg.sv =====
// hpg_pkg: shared types, constants and the cordic arctangent table
// for the hypotrochoid point generator; no dependencies
package hpg_pkg;

	localparam int unsigned ANGLE_W     = 32;
	localparam int unsigned PHASE_W     = 32;
	localparam int unsigned CORDIC_W    = 32;
	localparam int unsigned ATAN_COUNT  = 28;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	// 1/cordic gain at q2.30
	localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd652032874;

	typedef enum logic {
		REG_CIRCLE_RATIO = 1'b0,
		REG_PEN_RATIO    = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quadrant_t;

	typedef struct packed {
		logic [PHASE_W-1:0] ph2;
		logic [PHASE_W-1:0] ph1;
	} phase_pair_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// atan(2^-i) as a 32-bit fraction of a turn, rounded to nearest
	function automatic logic signed [CORDIC_W-1:0] atan_turn(input int unsigned idx);
		case (idx)
			0:  return 32'sd536870912;
			1:  return 32'sd316933406;
			2:  return 32'sd167458907;
			3:  return 32'sd85004756;
			4:  return 32'sd42667331;
			5:  return 32'sd21354465;
			6:  return 32'sd10679838;
			7:  return 32'sd5340245;
			8:  return 32'sd2670163;
			9:  return 32'sd1335087;
			10: return 32'sd667544;
			11: return 32'sd333772;
			12: return 32'sd166886;
			13: return 32'sd83443;
			14: return 32'sd41722;
			15: return 32'sd20861;
			16: return 32'sd10430;
			17: return 32'sd5215;
			18: return 32'sd2608;
			19: return 32'sd1304;
			20: return 32'sd652;
			21: return 32'sd326;
			22: return 32'sd163;
			23: return 32'sd81;
			24: return 32'sd41;
			25: return 32'sd20;
			26: return 32'sd10;
			27: return 32'sd5;
			default: return '0;
		endcase
	endfunction

endpackage

// ===== rtl/hpg_cfg.sv =====
// hpg_cfg: apb register file for the two ratios and the derived gains,
// with a bit-serial divider for the speed ratio; uses hpg_pkg
module hpg_cfg #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [hpg_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [hpg_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [hpg_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output logic [FRAC_BITS:0]                ring_gain,
	output logic [FRAC_BITS:0]                arm_gain,
	output logic [31:0]                       speed_ratio,
	output logic                              busy
);

	localparam int unsigned RW = FRAC_BITS + 1;
	localparam int unsigned NW = 2 * FRAC_BITS + 1;
	localparam int unsigned CW = $clog2(NW + 1);
	localparam logic [RW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [RW-1:0] HALF = ONE >> 1;

	logic [RW-1:0]      circle_q, pen_q, ring_q, arm_q, k_q, rem_q;
	logic [31:0]        speed_q;
	logic               busy_q;
	logic [NW-1:0]      num_q, quot_q;
	logic [CW-1:0]      cnt_q;

	logic               wr;
	hpg_pkg::reg_index_t widx;
	logic [RW-1:0]      wval, k_raw, l_raw, k_cl, l_cl, ring_nx, arm_nx, rem_nx;
	logic [2*RW-1:0]    prod_lk, arm_sum;
	logic [RW:0]        trial, diff;
	logic               ge;
	logic [NW-1:0]      quot_nx;
	logic [NW+31:0]     qx;
	logic [31:0]        speed_nx;

	assign wr    = psel & penable & pwrite;
	assign widx  = hpg_pkg::reg_index_t'(paddr[2]);
	assign wval  = pwdata[RW-1:0];
	assign pready = 1'b1;

	always_comb begin
		k_raw = (wr && widx == hpg_pkg::REG_CIRCLE_RATIO) ? wval : circle_q;
		l_raw = (wr && widx == hpg_pkg::REG_PEN_RATIO) ? wval : pen_q;
		if (k_raw == '0) begin
			k_cl = RW'(1);
		end else if (k_raw > ONE) begin
			k_cl = ONE;
		end else begin
			k_cl = k_raw;
		end
		l_cl    = (l_raw > ONE) ? ONE : l_raw;
		ring_nx = ONE - k_cl;
		prod_lk = l_cl * k_cl;
		arm_sum = prod_lk + {{RW{1'b0}}, HALF};
		arm_nx  = arm_sum[FRAC_BITS +: RW];
	end

	// restoring divide, one quotient bit a cycle
	always_comb begin
		trial    = {rem_q, num_q[NW-1]};
		diff     = trial - {1'b0, k_q};
		ge       = (trial >= {1'b0, k_q});
		rem_nx   = ge ? diff[RW-1:0] : trial[RW-1:0];
		quot_nx  = {quot_q[NW-2:0], ge};
		qx       = {32'b0, quot_nx};
		speed_nx = (|qx[NW+31:32]) ? '1 : qx[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circle_q <= HALF;
			pen_q    <= ONE;
			ring_q   <= HALF;
			arm_q    <= HALF;
			speed_q  <= 32'(ONE);
			busy_q   <= 1'b0;
			k_q      <= HALF;
			num_q    <= '0;
			rem_q    <= '0;
			quot_q   <= '0;
			cnt_q    <= '0;
		end else if (wr) begin
			unique case (widx)
				hpg_pkg::REG_CIRCLE_RATIO: circle_q <= wval;
				hpg_pkg::REG_PEN_RATIO:    pen_q    <= wval;
			endcase
			ring_q <= ring_nx;
			arm_q  <= arm_nx;
			k_q    <= k_cl;
			num_q  <= {ring_nx, {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			quot_q <= '0;
			cnt_q  <= CW'(NW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= rem_nx;
			quot_q <= quot_nx;
			cnt_q  <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q  <= 1'b0;
				speed_q <= speed_nx;
			end
		end
	end

	always_comb begin
		unique case (hpg_pkg::reg_index_t'(paddr[2]))
			hpg_pkg::REG_CIRCLE_RATIO: prdata = hpg_pkg::APB_DATA_W'(circle_q);
			hpg_pkg::REG_PEN_RATIO:    prdata = hpg_pkg::APB_DATA_W'(pen_q);
		endcase
	end

	assign ring_gain   = ring_q;
	assign arm_gain    = arm_q;
	assign speed_ratio = speed_q;
	assign busy        = busy_q;

	a_write_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		wr |=> busy_q) else $error("divider not started by register write");
	a_busy_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(wr)) else $error("divider started without a write");
	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("divider busy with zero count");

endmodule

// ===== rtl/hpg_front.sv =====
// hpg_front: accepts angle samples and forms both phases
// (fraction of t and fraction of speed_ratio * t); uses hpg_pkg
module hpg_front #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hpg_pkg::ANGLE_W-1:0]    s_tdata,    // [31:0] angle_turns
	input  logic                           cfg_busy,
	input  logic [31:0]                    speed_ratio,
	input  hpg_pkg::queue_status_t         q_status,
	output logic                           push,
	output hpg_pkg::phase_pair_t           push_data
);

	logic                              v_s1, v_s2, fe, acc;
	logic [hpg_pkg::ANGLE_W-1:0]       t_s1;
	logic [63:0]                       prod_s2;
	logic [hpg_pkg::PHASE_W-1:0]       ph1_s2, ph2;

	assign fe       = !v_s2 || !q_status.full;
	assign s_tready = fe && !cfg_busy;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (fe) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			t_s1    <= s_tdata;
			prod_s2 <= speed_ratio * t_s1;
			ph1_s2  <= {t_s1[FRAC_BITS-1:0], {(hpg_pkg::PHASE_W-FRAC_BITS){1'b0}}};
		end
	end

	// second phase: 2F fraction bits of the product as a 32-bit turn fraction
	generate
		if (2 * FRAC_BITS >= 32) begin : g_ph2_wide
			assign ph2 = prod_s2[2*FRAC_BITS-1 -: 32];
		end else begin : g_ph2_narrow
			assign ph2 = {prod_s2[2*FRAC_BITS-1:0], {(32-2*FRAC_BITS){1'b0}}};
		end
	endgenerate

	assign push          = v_s2 && !q_status.full;
	assign push_data.ph1 = ph1_s2;
	assign push_data.ph2 = ph2;

endmodule

// ===== rtl/hpg_queue.sv =====
// hpg_queue: short fifo of phase pairs between front and back
// uses hpg_pkg
module hpg_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  hpg_pkg::phase_pair_t      push_data,
	input  logic                      pop,
	output hpg_pkg::phase_pair_t      head,
	output hpg_pkg::queue_status_t    status
);

	localparam int unsigned PW = $clog2(hpg_pkg::QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(hpg_pkg::QUEUE_DEPTH + 1);

	hpg_pkg::phase_pair_t  mem_q [0:hpg_pkg::QUEUE_DEPTH-1];
	logic [PW-1:0]         wptr_q, rptr_q;
	logic [CW-1:0]         cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign head         = mem_q[rptr_q];
	assign status.full  = (cnt_q == CW'(hpg_pkg::QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full)) else $error("phase queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty)) else $error("phase queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(hpg_pkg::QUEUE_DEPTH)) else $error("phase queue count out of range");

endmodule

// ===== rtl/hpg_cordic.sv =====
// hpg_cordic: pipelined rotation cordic giving cos and sin at q2.30
// of a 32-bit turn fraction; uses hpg_pkg
module hpg_cordic #(
	parameter int unsigned CORDIC_STAGES = 18
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [hpg_pkg::PHASE_W-1:0]           phase,
	output logic signed [hpg_pkg::CORDIC_W-1:0]   cos_val,
	output logic signed [hpg_pkg::CORDIC_W-1:0]   sin_val
);

	localparam int unsigned W = hpg_pkg::CORDIC_W;

	logic signed [W-1:0]   x_s [0:CORDIC_STAGES];
	logic signed [W-1:0]   y_s [0:CORDIC_STAGES];
	logic signed [W-1:0]   z_s [0:CORDIC_STAGES];
	hpg_pkg::quadrant_t    quad_s [0:CORDIC_STAGES];
	logic signed [W-1:0]   cos_s, sin_s;

	// quadrant from the top two phase bits, rotate the rest
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= hpg_pkg::CORDIC_START;
			y_s[0]    <= '0;
			z_s[0]    <= {2'b00, phase[29:0]};
			quad_s[0] <= hpg_pkg::quadrant_t'(phase[31:30]);
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hpg_pkg::atan_turn(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hpg_pkg::atan_turn(i);
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[CORDIC_STAGES])
				hpg_pkg::QUAD_0: begin
					cos_s <= x_s[CORDIC_STAGES];
					sin_s <= y_s[CORDIC_STAGES];
				end
				hpg_pkg::QUAD_1: begin
					cos_s <= -y_s[CORDIC_STAGES];
					sin_s <= x_s[CORDIC_STAGES];
				end
				hpg_pkg::QUAD_2: begin
					cos_s <= -x_s[CORDIC_STAGES];
					sin_s <= -y_s[CORDIC_STAGES];
				end
				default: begin
					cos_s <= y_s[CORDIC_STAGES];
					sin_s <= -x_s[CORDIC_STAGES];
				end
			endcase
		end
	end

	assign cos_val = cos_s;
	assign sin_val = sin_s;

endmodule

// ===== rtl/hpg_back.sv =====
// hpg_back: two cordic lanes, gain multiply, sum, round and saturate,
// with a stall-all pipeline fed from the phase queue; uses hpg_pkg, hpg_cordic
module hpg_back #(
	parameter int unsigned FRAC_BITS     = 16,
	parameter int unsigned CORDIC_STAGES = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpg_pkg::queue_status_t        q_status,
	input  hpg_pkg::phase_pair_t          head,
	output logic                          pop,
	input  logic [FRAC_BITS:0]            ring_gain,
	input  logic [FRAC_BITS:0]            arm_gain,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata  // point_x, point_y
);

	localparam int unsigned L   = CORDIC_STAGES + 5;
	localparam int unsigned OW  = FRAC_BITS + 2;
	localparam int unsigned PW  = FRAC_BITS + 2 + hpg_pkg::CORDIC_W;
	localparam int unsigned SW  = PW + 1;
	localparam int unsigned VW  = SW - 30;
	localparam int unsigned TDW = ((2*(FRAC_BITS+2)+7)/8)*8;
	localparam logic signed [SW-1:0] RND = SW'(1) << 29;

	logic [L-1:0]                  vld_q;
	logic                          en;
	logic signed [hpg_pkg::CORDIC_W-1:0] c1, s1, c2, s2;
	logic signed [PW-1:0]          rc_s, rs_s, ac_s, as_s;
	logic signed [SW-1:0]          sx_s, sy_s, rx, ry;
	logic [VW-1:0]                 vx, vy;
	logic [VW-OW:0]                hx, hy;
	logic [OW-1:0]                 ox, oy, xo_s, yo_s;

	assign en  = !vld_q[L-1] || m_tready;
	assign pop = en && !q_status.empty;

	hpg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_ring (
		.clk(clk), .en(en), .phase(head.ph1), .cos_val(c1), .sin_val(s1)
	);

	hpg_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_lane_arm (
		.clk(clk), .en(en), .phase(head.ph2), .cos_val(c2), .sin_val(s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], pop};
		end
	end

	// round half up, then clamp when the bits above the sign disagree
	always_comb begin
		rx = sx_s + RND;
		ry = sy_s + RND;
		vx = rx[SW-1:30];
		vy = ry[SW-1:30];
		hx = vx[VW-1:OW-1];
		hy = vy[VW-1:OW-1];
		if (hx == '0 || hx == '1) begin
			ox = vx[OW-1:0];
		end else begin
			ox = {vx[VW-1], {(OW-1){!vx[VW-1]}}};
		end
		if (hy == '0 || hy == '1) begin
			oy = vy[OW-1:0];
		end else begin
			oy = {vy[VW-1], {(OW-1){!vy[VW-1]}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rc_s <= $signed({1'b0, ring_gain}) * c1;
			rs_s <= $signed({1'b0, ring_gain}) * s1;
			ac_s <= $signed({1'b0, arm_gain}) * c2;
			as_s <= $signed({1'b0, arm_gain}) * s2;
			sx_s <= SW'(rc_s) + SW'(ac_s);
			sy_s <= SW'(rs_s) - SW'(as_s);
			xo_s <= ox;
			yo_s <= oy;
		end
	end

	assign m_tvalid = vld_q[L-1];
	assign m_tdata  = TDW'({yo_s, xo_s});

endmodule

// ===== rtl/hypotrochoid_point_generator.sv =====
// hypotrochoid_point_generator: top level, spirograph point per angle sample
// uses hpg_pkg, hpg_cfg, hpg_front, hpg_queue, hpg_back, hpg_cordic
// path: an s_tdata transfer passes the front stages, the phase queue and the back pipeline to m_tdata
// throughput: one point per cycle unless m_tready or a running divide stalls it; fully pipelined cordic lanes
// a ratio write runs the serial divider with s_tready low until the divide is done
// reset: k = 0.5, l = 1.0, derived gains and speed ratio valid at once, pipes empty
module hypotrochoid_point_generator #(
	parameter int unsigned FRAC_BITS     = 16,
	parameter int unsigned CORDIC_STAGES = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// angle sample stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [hpg_pkg::ANGLE_W-1:0]           s_tdata,   // [31:0] angle_turns
	// point stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]  m_tdata,   // point_x, then point_y, zero pad
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [hpg_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [hpg_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [hpg_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	// derived gains, to be held steady by the user while samples are in flight; the block does not enforce it
	logic [FRAC_BITS:0]        ring_gain, arm_gain;
	logic [31:0]               speed_ratio;
	logic                      cfg_busy;

	// front to back handoff
	logic                      push, pop;
	hpg_pkg::phase_pair_t      push_data, head;
	hpg_pkg::queue_status_t    q_status;

	// register file plus divider for (1-k)/k
	hpg_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.ring_gain(ring_gain), .arm_gain(arm_gain),
		.speed_ratio(speed_ratio), .busy(cfg_busy)
	);

	// front: input transfer, phase of t and of speed_ratio * t
	hpg_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.cfg_busy(cfg_busy), .speed_ratio(speed_ratio),
		.q_status(q_status), .push(push), .push_data(push_data)
	);

	// short queue so a stalled output does not stall the input at once
	hpg_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data),
		.pop(pop), .head(head), .status(q_status)
	);

	// back: cordic lanes, gains, rounding, output register
	hpg_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_status(q_status), .head(head), .pop(pop),
		.ring_gain(ring_gain), .arm_gain(arm_gain),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
